// ----- rtl/tkpq_pkg.sv -----
// Shared types and constants for the touch key press qualifier.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package tkpq_pkg;

    // Width of every configuration register.
    localparam int CFG_W = 16;

    // Width of the key level and light fields on the ports.
    localparam int FIELD_KEYS = 2;

    // Request types carried by req_type.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PRESS_TICKS = 2'd0,
        CFG_LONG_HOLD   = 2'd1,
        CFG_RESTART     = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] PRESS_TICKS_RST = 16'd2;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST   = 16'd750;
    localparam logic [CFG_W-1:0] RESTART_RST     = 16'd1500;

    typedef struct packed {
        logic [CFG_W-1:0] press_ticks;
        logic [CFG_W-1:0] long_hold_ticks;
        logic [CFG_W-1:0] restart_ticks;
    } cfg_t;

    // Per-key status, as it stands after the current beat is applied.
    typedef struct packed {
        logic toggle;        // counter stepped onto press_ticks
        logic release_long;  // released with hold at or beyond long threshold
        logic over_long;     // hold beyond long threshold
        logic over_restart;  // hold beyond restart threshold
    } key_status_t;

endpackage

`default_nettype wire

// ----- rtl/tkpq_key_lane.sv -----
// One key's hold counter with its threshold compares.
// Depends on tkpq_pkg for the configuration and status types.
`default_nettype none

module tkpq_key_lane
    import tkpq_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        touched,
    input  wire cfg_t        cfg,
    output key_status_t      status
);

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_plus;
    logic                  at_max;

    assign at_max     = &count_reg;
    assign count_plus = count_reg + COUNT_BITS'(1);

    always_comb
    begin
        count_next = count_reg;
        if (step)
        begin
            if (!touched)
                count_next = '0;
            else if (!at_max)
                count_next = count_plus;
        end
    end

    // Compares run at the wider of the two widths so that neither side is cut.
    always_comb
    begin
        status.toggle       = step && touched && !at_max &&
                              (CMP_W'(count_plus) == CMP_W'(cfg.press_ticks));
        status.release_long = step && !touched &&
                              (CMP_W'(count_reg) >= CMP_W'(cfg.long_hold_ticks));
        status.over_long    = CMP_W'(count_next) > CMP_W'(cfg.long_hold_ticks);
        status.over_restart = CMP_W'(count_next) > CMP_W'(cfg.restart_ticks);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

`default_nettype wire

// ----- rtl/touch_key_press_qualifier.sv -----
// Touch key press qualifier: one result beat for every input beat.
// A result is ready the cycle after its beat; one beat per cycle while out_ready is high.
// The result sits in an output register; a new beat is taken whenever that register is
// empty or is being emptied in the same cycle. Reset is asynchronous, active low: counters
// clear, lights go off, thresholds return to 2, 750 and 1500, and no result is pending.
`default_nettype none

module touch_key_press_qualifier
    import tkpq_pkg::*;
#(
    parameter int NUM_KEYS   = 2,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             req_type,
    input  wire logic [1:0]       key_levels,
    input  wire logic             set_channel,
    input  wire logic             set_value,

    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            lights,
    output logic                  flash_active,
    output logic                  net_reset_pulse,
    output logic                  restart_request,
    output logic                  lights_changed,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    // The port fields are two keys wide; the key count may be larger or smaller.
    localparam int PAD_W = (NUM_KEYS > FIELD_KEYS) ? NUM_KEYS : FIELD_KEYS;

    // Configuration registers. Writes are always taken; an index past the
    // three registers is simply dropped.
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_ticks     <= PRESS_TICKS_RST;
            cfg_reg.long_hold_ticks <= LONG_HOLD_RST;
            cfg_reg.restart_ticks   <= RESTART_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PRESS_TICKS: cfg_reg.press_ticks     <= cfg_data;
                CFG_LONG_HOLD:   cfg_reg.long_hold_ticks <= cfg_data;
                CFG_RESTART:     cfg_reg.restart_ticks   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Handshake. The output register frees up in the same cycle it is read,
    // so a steady stream moves one beat per cycle.
    logic out_valid_reg;
    logic in_accept;
    logic is_tick;
    logic is_set;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign is_tick   = in_accept && (req_type == REQ_TICK);
    assign is_set    = in_accept && (req_type == REQ_SET);

    // Keys with no bit in key_levels read as level zero, that is, touched:
    // zero extension of the field gives exactly that.
    logic [PAD_W-1:0] levels_pad;

    assign levels_pad = PAD_W'(key_levels);

    key_status_t status [NUM_KEYS];

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        tkpq_key_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (is_tick),
            .touched (!levels_pad[k]),
            .cfg     (cfg_reg),
            .status  (status[k])
        );
    end

    // Lights. A tick toggles every light whose counter just reached the press
    // count; a remote set writes one light and leaves the counters alone.
    logic [NUM_KEYS-1:0] light_reg;
    logic [NUM_KEYS-1:0] light_next;
    logic                flash_next;
    logic                restart_next;
    logic                pulse_next;

    always_comb
    begin
        light_next   = light_reg;
        flash_next   = 1'b0;
        restart_next = 1'b0;
        pulse_next   = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (status[i].toggle)
                light_next[i] = !light_reg[i];
            if (is_set && (int'(set_channel) == i))
                light_next[i] = set_value;
            flash_next   = flash_next   | status[i].over_long;
            restart_next = restart_next | status[i].over_restart;
            pulse_next   = pulse_next   | status[i].release_long;
        end
    end

    logic [PAD_W-1:0] lights_pad;

    assign lights_pad = PAD_W'(light_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            light_reg <= light_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload; it only loads on an accepted beat, so a stalled result holds.
    logic [1:0] lights_reg;
    logic       flash_reg;
    logic       pulse_reg;
    logic       restart_reg;
    logic       changed_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lights_reg  <= lights_pad[1:0];
            flash_reg   <= flash_next;
            pulse_reg   <= pulse_next;
            restart_reg <= restart_next;
            changed_reg <= (light_next != light_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign lights          = lights_reg;
    assign flash_active    = flash_reg;
    assign net_reset_pulse = pulse_reg;
    assign restart_request = restart_reg;
    assign lights_changed  = changed_reg;

    // Every accepted beat leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    // A remote set never reports a network reset.
    a_set_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        is_set |=> !pulse_reg)
        else $error("remote set raised net_reset_pulse");

    // The change flag agrees with what actually happened to the light bits.
    a_changed_matches: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (changed_reg == (light_reg != $past(light_reg))))
        else $error("lights_changed disagrees with light state");

    // With every key released no hold can stand beyond any threshold.
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && (key_levels == 2'b11) && (NUM_KEYS <= FIELD_KEYS))
        |=> (!flash_reg && !restart_reg))
        else $error("flags raised with all keys released");

endmodule

`default_nettype wire
